// ===== src/bucketed_posting_index_builder_macros.svh =====
// Assertion helpers for the posting index builder.
`ifndef BUCKETED_POSTING_INDEX_BUILDER_MACROS_SVH
`define BUCKETED_POSTING_INDEX_BUILDER_MACROS_SVH

`ifndef SYNTH

`define BPIB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpib: assertion failed");

`define BPIB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpib: assertion failed");

`else

`define BPIB_ASSERT_IMPL(label, clk, rst, ante, cons)

`define BPIB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/bpib_pkg.sv =====
`timescale 1ns / 1ps

package bpib_pkg;

   localparam int NBUCKETS_DEFAULT = 1024;
   localparam int LIMIT_W          = 11;
   localparam int WBYTES_W         = 4;
   localparam int CSR_IDX_W        = 1;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_FINISH = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   localparam logic [1:0] KIND_POSTING = 2'd0;
   localparam logic [1:0] KIND_SEP     = 2'd1;
   localparam logic [1:0] KIND_TOTALS  = 2'd2;
   localparam logic [1:0] KIND_TABLE   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_BYTES   = 1'd1;

   localparam logic [WBYTES_W-1:0] WORD_BYTES_RESET = 4'd4;
   localparam logic signed [31:0]  SEP_WORD         = -32'sd1;
   localparam logic [15:0]         RUN_MAX          = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  bucket;
      logic [30:0] posting;
      logic [10:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] word;
      logic [31:0]        total_lines;
      logic [10:0]        buckets_used;
      logic [31:0]        bucket_offset;
      logic [15:0]        bucket_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic off_we;
      logic cnt_we;
      logic off_rd;
      logic cnt_rd;
   } tbl_ctl_type;

endpackage

// ===== src/bucketed_posting_index_builder.sv =====
`timescale 1ns / 1ps

// channel   ports                             handshake
// -------   -------------------------------   -------------------------------
// request   start, busy, req_item             taken when start && !busy
// result    rsp_valid, rsp_item               single-cycle valid, no stall
// config    csr_we, csr_index, csr_wdata      written when csr_we, no wait
//
// Add inside the current bucket: EXEC only. Add that opens a new bucket:
// EXEC emits a separator, SKIP steps one bucket index at a time, each step
// one offset and one count write. Finish: EXEC emits a separator, FIN fills
// offsets to the limit, then totals. Read: RDOUT gives the registered read.
// Synchronous reset; no clearing pass, the count table tracks a fill mark.

`include "bucketed_posting_index_builder_macros.svh"

module bucketed_posting_index_builder #(
   parameter int NBUCKETS = bpib_pkg::NBUCKETS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  bpib_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   output bpib_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_we,
   input  logic [bpib_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bpib_pkg::LIMIT_W-1:0]          csr_wdata
);

   localparam int AW = $clog2(NBUCKETS + 1);
   localparam int XW = (AW > bpib_pkg::LIMIT_W) ? AW : bpib_pkg::LIMIT_W;
   localparam logic [XW-1:0] NB_X = XW'(NBUCKETS);
   localparam logic [AW-1:0] NB_A = AW'(NBUCKETS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SKIP  = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_RDOUT = 3'd4;

   logic [2:0]                        state_ff, state_in;
   bpib_pkg::req_type                 item_ff, item_in;
   logic [XW-1:0]                     lim_ff, lim_in;
   logic [bpib_pkg::WBYTES_W-1:0]     wb_ff, wb_in;
   logic [AW-1:0]                     cb_ff, cb_in;
   logic [30:0]                       last_post_ff, last_post_in;
   logic                              have_last_ff, have_last_in;
   logic [15:0]                       run_ff, run_in;
   logic [31:0]                       bo_ff, bo_in;
   logic [31:0]                       total_ff, total_in;
   logic [10:0]                       used_ff, used_in;

   logic [AW-1:0]         eff_lim;
   logic [AW-1:0]         key_sat;
   logic [XW-1:0]         key_x;
   logic [XW-1:0]         ridx_x;
   logic [AW-1:0]         cb_nxt;
   logic                  post_new;
   logic [31:0]           wb_x;

   bpib_pkg::tbl_ctl_type tctl;
   logic [AW-1:0]         t_waddr;
   logic [31:0]           t_off_wdata;
   logic [15:0]           t_cnt_wdata;
   logic [AW-1:0]         t_raddr;
   logic [31:0]           t_rd_off;
   logic [15:0]           t_rd_cnt;

   always_comb begin
      if (lim_ff == '0) begin
         eff_lim = AW'(1);
      end else if (lim_ff > NB_X) begin
         eff_lim = NB_A;
      end else begin
         eff_lim = lim_ff[AW-1:0];
      end
      key_x = XW'(item_ff.bucket);
      if (key_x >= XW'(eff_lim)) begin
         key_sat = eff_lim - AW'(1);
      end else begin
         key_sat = key_x[AW-1:0];
      end
      ridx_x   = XW'(item_ff.read_index);
      cb_nxt   = cb_ff + AW'(1);
      post_new = !have_last_ff || (item_ff.posting != last_post_ff);
      wb_x     = 32'(wb_ff);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cb_in        = cb_ff;
      last_post_in = last_post_ff;
      have_last_in = have_last_ff;
      run_in       = run_ff;
      bo_in        = bo_ff;
      total_in     = total_ff;
      used_in      = used_ff;
      tctl         = '0;
      t_waddr      = cb_ff;
      t_off_wdata  = bo_ff;
      t_cnt_wdata  = run_ff;
      t_raddr      = ridx_x[AW-1:0];
      rsp_valid    = 1'b0;
      rsp_item     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in  = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (item_ff.action)
               bpib_pkg::ACT_ADD: begin
                  total_in = total_ff + 32'd1;
                  if (cb_ff < key_sat) begin
                     used_in       = used_ff + 11'd1;
                     rsp_valid     = 1'b1;
                     rsp_item.kind = bpib_pkg::KIND_SEP;
                     rsp_item.word = bpib_pkg::SEP_WORD;
                     tctl.cnt_we   = cb_ff < NB_A;
                     state_in      = S_SKIP;
                  end else begin
                     if (post_new) begin
                        rsp_valid     = 1'b1;
                        rsp_item.kind = bpib_pkg::KIND_POSTING;
                        rsp_item.word = $signed({1'b0, item_ff.posting});
                        rsp_item.last = 1'b1;
                        last_post_in  = item_ff.posting;
                        have_last_in  = 1'b1;
                        bo_in         = bo_ff + wb_x;
                        if (run_ff != bpib_pkg::RUN_MAX) begin
                           run_in = run_ff + 16'd1;
                        end
                     end
                     state_in = S_IDLE;
                  end
               end
               bpib_pkg::ACT_FINISH: begin
                  rsp_valid     = 1'b1;
                  rsp_item.kind = bpib_pkg::KIND_SEP;
                  rsp_item.word = bpib_pkg::SEP_WORD;
                  tctl.cnt_we   = cb_ff < NB_A;
                  state_in      = S_FIN;
               end
               bpib_pkg::ACT_READ: begin
                  tctl.off_rd = ridx_x <= NB_X;
                  tctl.cnt_rd = ridx_x < NB_X;
                  state_in    = S_RDOUT;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SKIP: begin
            // step over one bucket; the last step lands on the new key
            cb_in       = cb_nxt;
            t_waddr     = cb_nxt;
            t_cnt_wdata = 16'd0;
            tctl.off_we = 1'b1;
            tctl.cnt_we = 1'b1;
            if (cb_nxt == key_sat) begin
               t_off_wdata   = bo_ff + wb_x;
               rsp_valid     = 1'b1;
               rsp_item.kind = bpib_pkg::KIND_POSTING;
               rsp_item.word = $signed({1'b0, item_ff.posting});
               rsp_item.last = 1'b1;
               last_post_in  = item_ff.posting;
               have_last_in  = 1'b1;
               run_in        = 16'd1;
               bo_in         = bo_ff + {wb_x[30:0], 1'b0};
               state_in      = S_IDLE;
            end
         end
         S_FIN: begin
            if (cb_ff < eff_lim) begin
               cb_in       = cb_nxt;
               t_waddr     = cb_nxt;
               t_cnt_wdata = 16'd0;
               tctl.off_we = 1'b1;
               tctl.cnt_we = cb_nxt < NB_A;
            end else begin
               rsp_valid             = 1'b1;
               rsp_item.kind         = bpib_pkg::KIND_TOTALS;
               rsp_item.total_lines  = total_ff;
               rsp_item.buckets_used = used_ff;
               rsp_item.last         = 1'b1;
               state_in              = S_IDLE;
            end
         end
         S_RDOUT: begin
            rsp_valid              = 1'b1;
            rsp_item.kind          = bpib_pkg::KIND_TABLE;
            rsp_item.bucket_offset = t_rd_off;
            rsp_item.bucket_count  = t_rd_cnt;
            rsp_item.last          = 1'b1;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      lim_in = lim_ff;
      wb_in  = wb_ff;
      if (csr_we) begin
         unique case (csr_index)
            bpib_pkg::CSR_BUCKET_LIMIT: lim_in = XW'(csr_wdata);
            bpib_pkg::CSR_WORD_BYTES:   wb_in  = csr_wdata[bpib_pkg::WBYTES_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lim_ff       <= NB_X;
         wb_ff        <= bpib_pkg::WORD_BYTES_RESET;
         cb_ff        <= '0;
         last_post_ff <= '0;
         have_last_ff <= 1'b0;
         run_ff       <= '0;
         bo_ff        <= '0;
         total_ff     <= '0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         lim_ff       <= lim_in;
         wb_ff        <= wb_in;
         cb_ff        <= cb_in;
         last_post_ff <= last_post_in;
         have_last_ff <= have_last_in;
         run_ff       <= run_in;
         bo_ff        <= bo_in;
         total_ff     <= total_in;
         used_ff      <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign busy = state_ff != S_IDLE;

   bpib_tables #(
      .NBUCKETS (NBUCKETS)
   ) u_tables (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tctl),
      .waddr     (t_waddr),
      .off_wdata (t_off_wdata),
      .cnt_wdata (t_cnt_wdata),
      .raddr     (t_raddr),
      .rd_off    (t_rd_off),
      .rd_cnt    (t_rd_cnt)
   );

   `BPIB_ASSERT_NEXT(a_last_then_idle, clock, reset, rsp_valid && rsp_item.last, !busy)
   `BPIB_ASSERT_IMPL(a_skip_below_key, clock, reset, state_ff == S_SKIP, cb_ff < key_sat)
   `BPIB_ASSERT_IMPL(a_run_nonzero, clock, reset, have_last_ff, run_ff != 16'd0)

endmodule

// ===== src/bpib_tables.sv =====
`timescale 1ns / 1ps

`include "bucketed_posting_index_builder_macros.svh"

module bpib_tables #(
   parameter int NBUCKETS = bpib_pkg::NBUCKETS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bpib_pkg::tbl_ctl_type             ctl,
   input  logic [$clog2(NBUCKETS + 1)-1:0]   waddr,
   input  logic [31:0]                       off_wdata,
   input  logic [15:0]                       cnt_wdata,
   input  logic [$clog2(NBUCKETS + 1)-1:0]   raddr,
   output logic [31:0]                       rd_off,
   output logic [15:0]                       rd_cnt
);

   localparam int AW = $clog2(NBUCKETS + 1);
   localparam int CW = $clog2(NBUCKETS);

   logic [31:0] off_mem [NBUCKETS + 1];
   logic [15:0] cnt_mem [NBUCKETS];

   logic [31:0]   off_q;
   logic [15:0]   cnt_q;
   logic [AW-1:0] fill_ff, fill_in;
   logic          off_ok_ff, off_ok_in;
   logic          cnt_ok_ff, cnt_ok_in;

   // count entries below fill_ff have been written; the rest read as zero
   always_comb begin
      fill_in = fill_ff;
      if (ctl.cnt_we && (waddr >= fill_ff)) begin
         fill_in = waddr + AW'(1);
      end
      off_ok_in = ctl.off_rd && (raddr != '0);
      cnt_ok_in = ctl.cnt_rd && (raddr < fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         off_ok_ff <= 1'b0;
         cnt_ok_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         off_ok_ff <= off_ok_in;
         cnt_ok_ff <= cnt_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.off_we) begin
         off_mem[waddr] <= off_wdata;
      end
      if (ctl.off_rd) begin
         off_q <= off_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cnt_we) begin
         cnt_mem[waddr[CW-1:0]] <= cnt_wdata;
      end
      if (ctl.cnt_rd) begin
         cnt_q <= cnt_mem[raddr[CW-1:0]];
      end
   end

   assign rd_off = off_ok_ff ? off_q : 32'd0;
   assign rd_cnt = cnt_ok_ff ? cnt_q : 16'd0;

   `BPIB_ASSERT_IMPL(a_cnt_wr_contig, clock, reset, ctl.cnt_we, waddr <= fill_ff)
   `BPIB_ASSERT_IMPL(a_no_rd_wr_mix, clock, reset, ctl.off_rd || ctl.cnt_rd, !ctl.off_we && !ctl.cnt_we)

endmodule
